// File: rtl/kalman_motion_trajectory_smoother_assert.svh
// Assertion macros for the trajectory smoother.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef KALMAN_MOTION_TRAJECTORY_SMOOTHER_ASSERT_SVH
`define KALMAN_MOTION_TRAJECTORY_SMOOTHER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KMTS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define KMTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/kmts_pkg.sv
`timescale 1ns / 1ps
package kmts_pkg;

  // Channel layout: shift x, shift y, angle, zoom x, zoom y.
  localparam int CHANNELS   = 5;
  localparam int CH_W       = $clog2(CHANNELS);
  localparam int FIRST_ZOOM = 3;

  // Field and state widths.
  localparam int FIELD_W = 32;
  localparam int ANGLE_W = 19;
  localparam int TRAJ_W  = 48;
  localparam int COV_W   = 32;
  localparam int GAIN_W  = 31;
  localparam int MUL_W   = 32;
  localparam int PADDR_W = 3;

  // Fixed-point constants, Q2.30 for noise and covariance.
  localparam logic [GAIN_W-1:0] Q30_ONE       = 31'h4000_0000;
  localparam logic [COV_W-1:0]  COV_RESET     = 32'h4000_0000;
  localparam logic [COV_W-1:0]  PNOISE_RESET  = 32'd4294967;
  localparam logic [COV_W-1:0]  MNOISE_RESET  = 32'd536870912;

  // Register indexes, taken from paddr bit 2.
  localparam logic REG_PROCESS_NOISE     = 1'b0;
  localparam logic REG_MEASUREMENT_NOISE = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_COV,
    ST_COVW,
    ST_RD,
    ST_TRJ,
    ST_MHI,
    ST_MLO,
    ST_UPD,
    ST_DONE
  } kmts_state_t;

  // Status of the gain divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // One entry of the channel state memory.
  typedef struct packed {
    logic signed [TRAJ_W-1:0] traj;
    logic signed [TRAJ_W-1:0] est;
  } ram_entry_t;

endpackage

// File: rtl/kmts_gain_div.sv
`timescale 1ns / 1ps
module kmts_gain_div import kmts_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [COV_W-1:0]  p,
  input  logic [COV_W-1:0]  r,
  output logic [GAIN_W-1:0] gain,
  output div_stat_t         stat
);

  localparam int DEN_W = COV_W + 1;
  localparam int REM_W = DEN_W + 1;
  localparam int CNT_W = $clog2(GAIN_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [REM_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [GAIN_W-1:0] q_r;
  logic              zero_r;
  logic [DEN_W-1:0]  den_sum;
  logic              fits;
  logic [REM_W-1:0]  rem_sub;

  // Restoring division of p * 2^30 by (p + r), one quotient bit a cycle.
  assign den_sum = {1'b0, p} + {1'b0, r};
  assign fits    = rem_r >= {1'b0, den_r};
  assign rem_sub = fits ? rem_r - {1'b0, den_r} : rem_r;

  // Control: busy for one step per quotient bit, then a done pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && cnt_r == '0) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end else begin
      done_r <= 1'b0;
    end
  end

  // Datapath: the first step compares p itself, later steps the doubled remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= REM_W'(p);
      den_r  <= den_sum;
      zero_r <= (den_sum == '0);
      cnt_r  <= CNT_W'(GAIN_W - 1);
      q_r    <= '0;
    end else if (busy_r) begin
      rem_r <= {rem_sub[REM_W-2:0], 1'b0};
      q_r   <= {q_r[GAIN_W-2:0], fits};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // A zero denominator gives zero gain.
  assign gain      = zero_r ? '0 : q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// File: rtl/kmts_mul.sv
`timescale 1ns / 1ps
module kmts_mul import kmts_pkg::*; (
  input  logic                 clk,
  input  logic [MUL_W-1:0]     a,
  input  logic [MUL_W-1:0]     b,
  output logic [2*MUL_W-1:0]   prod_r
);

  // Shared unsigned multiplier with its product registered.
  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

// File: rtl/kmts_state_ram.sv
`timescale 1ns / 1ps
module kmts_state_ram import kmts_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            we,
  input  logic [CH_W-1:0] waddr,
  input  ram_entry_t      wdata,
  input  logic            re,
  input  logic [CH_W-1:0] raddr,
  output ram_entry_t      rdata
);

  ram_entry_t           mem [CHANNELS];
  ram_entry_t           rdata_r;
  logic                 rvld_r;
  logic [CHANNELS-1:0]  vld_r;

  // Storage write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  // Per-entry valid bits; an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        rvld_r <= vld_r[raddr];
      end
    end
  end

  assign rdata = rvld_r ? rdata_r : '0;

endmodule

// File: rtl/kalman_motion_trajectory_smoother.sv
// Kalman trajectory smoother for video stabilization.
// The input channel takes one frame's motion (shift x/y, angle, zoom x/y,
// signed Q16.16, the angle signed Q3.16) with valid/ready; the output
// channel returns the five corrected values with valid/ready. Process and
// measurement noise are written over the APB port at byte addresses 0 and 4;
// the user is to write them only while the block idles, which the block
// itself does not enforce. Each item passes through the radix-2 gain divider,
// the covariance product and, per channel, a read, a multiply in two halves
// and a write back through the channel state memory and the shared 32x32
// multiplier; only then does the block return to idle and accept the next item.
// The output register holds a finished result while the receiver stalls;
// the next item is still accepted and worked on, and only its final
// hand-off to the output register waits for the receiver.
// Synchronous reset clears trajectory and estimates, sets the covariance to
// one, marks the next frame as the first, and restores the noise defaults.
`timescale 1ns / 1ps
`include "kalman_motion_trajectory_smoother_assert.svh"
module kalman_motion_trajectory_smoother import kmts_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [FIELD_W-1:0] in_shift_x,
  input  logic signed [FIELD_W-1:0] in_shift_y,
  input  logic signed [ANGLE_W-1:0] in_angle,
  input  logic signed [FIELD_W-1:0] in_zoom_x,
  input  logic signed [FIELD_W-1:0] in_zoom_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [FIELD_W-1:0] out_smooth_shift_x,
  output logic signed [FIELD_W-1:0] out_smooth_shift_y,
  output logic signed [FIELD_W-1:0] out_smooth_angle,
  output logic signed [FIELD_W-1:0] out_smooth_zoom_x,
  output logic signed [FIELD_W-1:0] out_smooth_zoom_y,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PADDR_W-1:0]        paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int ADD_W = FIELD_W + 2;
  localparam int SUM_W = TRAJ_W + 2;
  localparam int MAG_W = TRAJ_W + 1;
  localparam logic signed [ADD_W-1:0] ZOOM_ONE = ADD_W'(1) << FRAC_BITS;
  localparam logic [TRAJ_W-1:0] TRAJ_MAX = {1'b0, {(TRAJ_W-1){1'b1}}};
  localparam logic [TRAJ_W-1:0] TRAJ_MIN = {1'b1, {(TRAJ_W-1){1'b0}}};
  localparam logic [FIELD_W-1:0] OUT_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam logic [FIELD_W-1:0] OUT_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

  kmts_state_t state_r, state_nxt;

  logic [COV_W-1:0]          pnoise_r;
  logic [COV_W-1:0]          mnoise_r;
  logic [COV_W-1:0]          cov_r;
  logic                      first_r;
  logic [CH_W-1:0]           ch_r;
  logic                      out_valid_r;
  logic [COV_W-1:0]          p_r;
  logic signed [FIELD_W-1:0] val_r [CHANNELS];
  logic signed [FIELD_W-1:0] res_r [CHANNELS];
  logic signed [TRAJ_W-1:0]  traj_r;
  logic signed [TRAJ_W-1:0]  est_r;
  logic [MAG_W-1:0]          mag_r;
  logic                      neg_r;
  logic [SUM_W-1:0]          hi_r;
  logic signed [FIELD_W-1:0] out_sx_r, out_sy_r, out_ang_r, out_zx_r, out_zy_r;

  logic                      cfg_wr;
  logic                      in_acc;
  logic                      out_load;
  logic [COV_W:0]            p_sum;
  logic [COV_W-1:0]          p_nxt;
  logic [GAIN_W-1:0]         div_gain;
  div_stat_t                 div_stat;
  logic [MUL_W-1:0]          mul_a, mul_b;
  logic [2*MUL_W-1:0]        prod;
  logic                      ram_re, ram_we;
  ram_entry_t                ram_rd, ram_wr;
  logic signed [FIELD_W-1:0] val_cur;
  logic [ADD_W-1:0]          add_v;
  logic [SUM_W-1:0]          traj_sum;
  logic [TRAJ_W-1:0]         traj_new;
  logic [MAG_W-1:0]          diff;
  logic [SUM_W-1:0]          r_sum;
  logic [SUM_W-1:0]          est_ext;
  logic [SUM_W-1:0]          est_upd;
  logic [TRAJ_W-1:0]         est_new;
  logic [SUM_W-1:0]          out_sum;
  logic [FIELD_W-1:0]        out_sat;

  // Configuration port: always ready, write on the access phase.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pnoise_r <= PNOISE_RESET;
      mnoise_r <= MNOISE_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_PROCESS_NOISE:     pnoise_r <= pwdata;
        REG_MEASUREMENT_NOISE: mnoise_r <= pwdata;
        default:               pnoise_r <= pnoise_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_PROCESS_NOISE:     prdata = pnoise_r;
      REG_MEASUREMENT_NOISE: prdata = mnoise_r;
      default:               prdata = '0;
    endcase
  end

  // Predicted covariance, saturated at all ones.
  assign in_acc = in_valid && in_ready;
  assign p_sum  = {1'b0, cov_r} + {1'b0, pnoise_r};
  assign p_nxt  = p_sum[COV_W] ? '1 : p_sum[COV_W-1:0];

  kmts_gain_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .p     (p_nxt),
    .r     (mnoise_r),
    .gain  (div_gain),
    .stat  (div_stat)
  );

  kmts_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  kmts_state_ram u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (ram_we),
    .waddr (ch_r),
    .wdata (ram_wr),
    .re    (ram_re),
    .raddr (ch_r),
    .rdata (ram_rd)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state, handshake and multiplier operand selection.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_COV;
        end
      end
      ST_COV: begin
        mul_a     = MUL_W'(Q30_ONE - div_gain);
        mul_b     = p_r;
        state_nxt = ST_COVW;
      end
      ST_COVW: begin
        state_nxt = ST_RD;
      end
      ST_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_TRJ;
      end
      ST_TRJ: begin
        state_nxt = ST_MHI;
      end
      ST_MHI: begin
        mul_a     = MUL_W'(mag_r[MAG_W-1:30]);
        mul_b     = MUL_W'(div_gain);
        state_nxt = ST_MLO;
      end
      ST_MLO: begin
        mul_a     = MUL_W'(mag_r[29:0]);
        mul_b     = MUL_W'(div_gain);
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        ram_we = 1'b1;
        if (ch_r == CH_W'(CHANNELS - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Trajectory update for the channel just read, saturated to 48 bits.
  assign val_cur  = val_r[ch_r];
  assign add_v    = {{2{val_cur[FIELD_W-1]}}, val_cur}
                    - ((ch_r >= CH_W'(FIRST_ZOOM)) ? ZOOM_ONE : '0);
  assign traj_sum = {{2{ram_rd.traj[TRAJ_W-1]}}, ram_rd.traj}
                    + {{(SUM_W-ADD_W){add_v[ADD_W-1]}}, add_v};
  assign traj_new = (traj_sum[SUM_W-1:TRAJ_W-1] == '0 || traj_sum[SUM_W-1:TRAJ_W-1] == '1)
                    ? traj_sum[TRAJ_W-1:0]
                    : (traj_sum[SUM_W-1] ? TRAJ_MIN : TRAJ_MAX);
  assign diff     = {traj_new[TRAJ_W-1], traj_new} - {ram_rd.est[TRAJ_W-1], ram_rd.est};

  // Estimate step: gain times the magnitude, truncated toward zero.
  assign r_sum   = hi_r + SUM_W'(prod[60:30]);
  assign est_ext = {{2{est_r[TRAJ_W-1]}}, est_r};
  assign est_upd = neg_r ? est_ext - r_sum : est_ext + r_sum;
  assign est_new = first_r ? est_r : est_upd[TRAJ_W-1:0];
  assign ram_wr  = '{traj: traj_r, est: est_new};

  // Result for this channel: input plus estimate minus trajectory, saturated.
  assign out_sum = {{(SUM_W-FIELD_W){val_cur[FIELD_W-1]}}, val_cur}
                   + {{2{est_new[TRAJ_W-1]}}, est_new}
                   - {{2{traj_r[TRAJ_W-1]}}, traj_r};
  assign out_sat = (out_sum[SUM_W-1:FIELD_W-1] == '0 || out_sum[SUM_W-1:FIELD_W-1] == '1)
                   ? out_sum[FIELD_W-1:0]
                   : (out_sum[SUM_W-1] ? OUT_MIN : OUT_MAX);

  // Control state: covariance, first-frame flag, channel counter, output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cov_r       <= COV_RESET;
      first_r     <= 1'b1;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_COVW && !first_r) begin
        cov_r <= prod[61:30];
      end
      if (state_r == ST_COVW) begin
        ch_r <= '0;
      end else if (state_r == ST_UPD && ch_r != CH_W'(CHANNELS - 1)) begin
        ch_r <= ch_r + 1'b1;
      end
      if (out_load) begin
        first_r     <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Input capture, sign-extended to the common field width.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      val_r[0] <= in_shift_x;
      val_r[1] <= in_shift_y;
      val_r[2] <= {{(FIELD_W-ANGLE_W){in_angle[ANGLE_W-1]}}, in_angle};
      val_r[3] <= in_zoom_x;
      val_r[4] <= in_zoom_y;
      p_r      <= p_nxt;
    end
  end

  // Per-channel working registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_TRJ: begin
        traj_r <= traj_new;
        est_r  <= ram_rd.est;
        neg_r  <= diff[MAG_W-1];
        mag_r  <= diff[MAG_W-1] ? -diff : diff;
      end
      ST_MLO: begin
        hi_r <= prod[SUM_W-1:0];
      end
      ST_UPD: begin
        res_r[ch_r] <= out_sat;
      end
      default: begin
        hi_r <= hi_r;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sx_r  <= res_r[0];
      out_sy_r  <= res_r[1];
      out_ang_r <= res_r[2];
      out_zx_r  <= res_r[3];
      out_zy_r  <= res_r[4];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_smooth_shift_x = out_sx_r;
  assign out_smooth_shift_y = out_sy_r;
  assign out_smooth_angle   = out_ang_r;
  assign out_smooth_zoom_x  = out_zx_r;
  assign out_smooth_zoom_y  = out_zy_r;

  // Checks on the sequencer and the gain divider.
  `KMTS_ASSERT_NEXT(a_accept_starts_div, in_valid && in_ready, div_stat.busy && state_r == ST_DIV, "accepted item did not start the gain divider")
  `KMTS_ASSERT_IMPLY(a_div_done_in_wait, div_stat.done, state_r == ST_DIV, "gain divider finished outside its wait state")
  `KMTS_ASSERT_IMPLY(a_gain_range, div_stat.done, div_gain <= Q30_ONE, "gain above one")
  `KMTS_ASSERT_IMPLY(a_out_from_done, $rose(out_valid_r), $past(state_r) == ST_DONE, "result presented before all channels finished")

endmodule
